// ===== sv/psq_pkg.sv =====
// ----------------------------------------------------------------------------
// psq_pkg: shared definitions for the priority stack queue
// Commands, status codes, default sizes and the per-cell control struct.
// ----------------------------------------------------------------------------
package psq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int PRIO_WIDTH_DEF  = 16;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// ===== sv/priority_stack_queue.sv =====
// ----------------------------------------------------------------------------
// priority_stack_queue: bounded priority stack built as a chain of slots
// Each input transfer loads its result into the output register. Throughput:
// one item per cycle unless stalled; all slots compare and shift in parallel.
// Reset clears the entry count and the output valid; slot contents are left.
// ----------------------------------------------------------------------------
module priority_stack_queue #(
  parameter int DEPTH       = psq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = psq_pkg::VALUE_WIDTH_DEF,
  parameter int PRIO_WIDTH  = psq_pkg::PRIO_WIDTH_DEF,
  localparam int CntW  = $clog2(DEPTH + 1),
  localparam int InW   = ((VALUE_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
  localparam int OutW  = ((2 * VALUE_WIDTH + 2 * PRIO_WIDTH + CntW + 1 + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // item_value, item_priority
  input  logic [InW-1:0]                in_tdata,
  // cmd
  input  logic [psq_pkg::CMD_W-1:0]     in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // head_value, head_priority, entry_count, is_empty, popped_value,
  // popped_priority
  output logic [OutW-1:0]               out_tdata,
  // status
  output logic [psq_pkg::STATUS_W-1:0]  out_tuser
);
  import psq_pkg::*;

  localparam int ResW = 2 * VALUE_WIDTH + 2 * PRIO_WIDTH + CntW + 1;

  logic [VALUE_WIDTH-1:0] item_value;
  logic [PRIO_WIDTH-1:0]  item_priority;
  logic                   xfer;
  logic                   full;
  logic                   empty;
  cell_ctrl_t             ctrl;
  logic [STATUS_W-1:0]    status;

  logic [CntW-1:0] count_r, count_nxt;
  logic            out_valid_r;
  logic [OutW-1:0] out_data_r;
  logic [STATUS_W-1:0] out_user_r;

  logic                   greater   [DEPTH];
  logic [VALUE_WIDTH-1:0] value_q   [DEPTH];
  logic [PRIO_WIDTH-1:0]  prio_q    [DEPTH];
  logic [VALUE_WIDTH-1:0] value_nxt [DEPTH];
  logic [PRIO_WIDTH-1:0]  prio_nxt  [DEPTH];

  logic [VALUE_WIDTH-1:0] head_value, popped_value;
  logic [PRIO_WIDTH-1:0]  head_prio, popped_prio;

  assign item_value    = in_tdata[VALUE_WIDTH-1:0];
  assign item_priority = in_tdata[VALUE_WIDTH +: PRIO_WIDTH];

  assign in_tready = !out_valid_r || out_tready;
  assign xfer      = in_tvalid && in_tready;
  assign full      = (count_r == CntW'(DEPTH));
  assign empty     = (count_r == '0);

  always_comb begin
    ctrl.push = 1'b0;
    ctrl.pop  = 1'b0;
    status    = ST_OK;
    count_nxt = count_r;
    case (in_tuser)
      CMD_PUSH: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ctrl.push = xfer;
          count_nxt = count_r + CntW'(1);
        end
      end
      CMD_POP: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ctrl.pop  = xfer;
          count_nxt = count_r - CntW'(1);
        end
      end
      CMD_PEEK: begin
        status = ST_OK;
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   occ;
    logic                   lg;
    logic [VALUE_WIDTH-1:0] lv, rv;
    logic [PRIO_WIDTH-1:0]  lp, rp;

    assign occ = (count_r > CntW'(i));

    if (i == 0) begin : g_first
      assign lg = 1'b1;
      assign lv = item_value;
      assign lp = item_priority;
    end else begin : g_mid
      assign lg = greater[i-1];
      assign lv = value_q[i-1];
      assign lp = prio_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = value_q[i];
      assign rp = prio_q[i];
    end else begin : g_inner
      assign rv = value_q[i+1];
      assign rp = prio_q[i+1];
    end

    psq_cell #(
      .VW (VALUE_WIDTH),
      .PW (PRIO_WIDTH)
    ) u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .occupied     (occ),
      .new_value    (item_value),
      .new_prio     (item_priority),
      .left_greater (lg),
      .left_value   (lv),
      .left_prio    (lp),
      .right_value  (rv),
      .right_prio   (rp),
      .greater      (greater[i]),
      .value_q      (value_q[i]),
      .prio_q       (prio_q[i]),
      .value_nxt    (value_nxt[i]),
      .prio_nxt     (prio_nxt[i])
    );
  end

  always_comb begin
    if (count_nxt == '0) begin
      head_value = '0;
      head_prio  = '0;
    end else begin
      head_value = value_nxt[0];
      head_prio  = prio_nxt[0];
    end
    if (ctrl.pop) begin
      popped_value = value_q[0];
      popped_prio  = prio_q[0];
    end else begin
      popped_value = '0;
      popped_prio  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (xfer) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      out_data_r <= OutW'(ResW'({popped_prio, popped_value, (count_nxt == '0),
                                 count_nxt, head_prio, head_value}));
      out_user_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== sv/psq_cell.sv =====
// ----------------------------------------------------------------------------
// psq_cell: one slot of the sorted chain
// Holds one entry and on each step keeps it, loads the pushed item, or takes
// the entry of its left or right neighbor.
// ----------------------------------------------------------------------------
module psq_cell #(
  parameter int VW = 32,
  parameter int PW = 16
) (
  input  logic                clk,
  input  psq_pkg::cell_ctrl_t ctrl,
  input  logic                occupied,
  input  logic [VW-1:0]       new_value,
  input  logic [PW-1:0]       new_prio,
  input  logic                left_greater,
  input  logic [VW-1:0]       left_value,
  input  logic [PW-1:0]       left_prio,
  input  logic [VW-1:0]       right_value,
  input  logic [PW-1:0]       right_prio,
  output logic                greater,
  output logic [VW-1:0]       value_q,
  output logic [PW-1:0]       prio_q,
  output logic [VW-1:0]       value_nxt,
  output logic [PW-1:0]       prio_nxt
);
  import psq_pkg::*;

  logic [VW-1:0] value_r;
  logic [PW-1:0] prio_r;

  assign greater = occupied && (prio_r > new_prio);

  always_comb begin
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (ctrl.push && !greater) begin
      if (left_greater) begin
        value_nxt = new_value;
        prio_nxt  = new_prio;
      end else begin
        value_nxt = left_value;
        prio_nxt  = left_prio;
      end
    end else if (ctrl.pop) begin
      value_nxt = right_value;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign value_q = value_r;
  assign prio_q  = prio_r;

endmodule
